/* rtl/core/bid_pkg.sv */
// ----------------------------------------------------------------------------
// bid_pkg
// Shared types and constants for the black interval detector: item formats,
// configuration register map and derived-configuration bundle.
// ----------------------------------------------------------------------------
package bid_pkg;

  // Configuration port
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 48;

  // Field and datapath widths
  localparam int unsigned PixW      = 16;
  localparam int unsigned CountW    = 27;
  localparam int unsigned RatioW    = 17;
  localparam int unsigned NpixW     = 27;
  localparam int unsigned ProdW     = RatioW + NpixW;
  localparam int unsigned DurW      = 48;
  localparam int unsigned PtsW      = 64;
  localparam int unsigned DepthW    = 5;

  // Frame size clamp and count saturation
  localparam logic [NpixW-1:0]  MaxFramePixels = NpixW'(67108864);
  localparam logic [CountW-1:0] CountMax       = '1;

  // Reset values of the registers
  localparam logic [15:0]        PixThrReset   = 16'd6554;
  localparam logic [RatioW-1:0]  RatioReset    = RatioW'(64225);
  localparam logic [DurW-1:0]    MinDurReset   = '0;
  localparam logic [NpixW-1:0]   FramePixReset = NpixW'(1);
  localparam logic [DepthW-1:0]  DepthReset    = DepthW'(8);

  // Register map
  typedef enum logic [CfgIndexW-1:0] {
    RegPixelThreshold = 3'd0,
    RegRatioThreshold = 3'd1,
    RegMinDuration    = 3'd2,
    RegFramePixels    = 3'd3,
    RegBitDepth       = 3'd4,
    RegAlphaMode      = 3'd5
  } bid_reg_e;

  // Input item
  typedef struct packed {
    logic                   mode;
    logic [PixW-1:0]        pixel_value;
    logic                   full_range;
    logic                   frame_last;
    logic signed [PtsW-1:0] frame_pts;
  } bid_in_t;

  // Result item
  typedef struct packed {
    logic                   frame_black;
    logic                   start_event;
    logic                   end_event;
    logic                   interval_long_enough;
    logic signed [PtsW-1:0] interval_start;
    logic signed [PtsW-1:0] interval_end;
  } bid_out_t;

  // Derived configuration handed to the datapath
  typedef struct packed {
    logic [PixW-1:0]  limit_full;
    logic [PixW-1:0]  limit_ltd;
    logic             alpha_mode;
    logic [ProdW-1:0] ratio_npix;
    logic [DurW-1:0]  min_duration;
  } bid_cfg_t;

endpackage

/* rtl/core/black_interval_detector.sv */
// ----------------------------------------------------------------------------
// black_interval_detector
// Path: input register, then result register; throughput one item per cycle
// while the output is not stalled, set by the single pass.
// Reset (async, active low) restores register defaults and clears the count,
// interval state and both valid flags. A stalled output holds the input side.
// Counts dark pixels per frame, marks black frames and reports black intervals.
// ----------------------------------------------------------------------------
module black_interval_detector
  import bid_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bid_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bid_out_t             out_data_o
);

  bid_cfg_t cfg;

  // Configuration and derived thresholds
  bid_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Datapath
  bid_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* rtl/core/bid_cfg_regs.sv */
// ----------------------------------------------------------------------------
// bid_cfg_regs
// Configuration registers plus registered derived values: pixel limits for
// full and limited range, and the ratio times frame size product.
// ----------------------------------------------------------------------------
module bid_cfg_regs
  import bid_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  output bid_cfg_t             cfg_o
);

  logic [15:0]       pix_thr_q;
  logic [RatioW-1:0] ratio_q;
  logic [DurW-1:0]   min_dur_q;
  logic [NpixW-1:0]  frame_pix_q;
  logic [DepthW-1:0] depth_q;
  logic              alpha_q;

  logic [3:0]        shamt;
  logic [DepthW-1:0] depth_c;
  logic [31:0]       full_prod;
  logic [23:0]       thr_x219;
  logic [31:0]       ltd_prod;
  logic [15:0]       ltd_base;
  logic [NpixW-1:0]  npix;
  bid_cfg_t          cfg_d, cfg_q;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_thr_q   <= PixThrReset;
      ratio_q     <= RatioReset;
      min_dur_q   <= MinDurReset;
      frame_pix_q <= FramePixReset;
      depth_q     <= DepthReset;
      alpha_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (bid_reg_e'(cfg_index_i))
        RegPixelThreshold: pix_thr_q   <= cfg_data_i[15:0];
        RegRatioThreshold: ratio_q     <= cfg_data_i[RatioW-1:0];
        RegMinDuration:    min_dur_q   <= cfg_data_i[DurW-1:0];
        RegFramePixels:    frame_pix_q <= cfg_data_i[NpixW-1:0];
        RegBitDepth:       depth_q     <= cfg_data_i[DepthW-1:0];
        RegAlphaMode:      alpha_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Depth clamped to 8..16, shift is depth - 8
  always_comb begin
    if (depth_q < DepthW'(8)) begin
      depth_c = DepthW'(8);
    end else if (depth_q > DepthW'(16)) begin
      depth_c = DepthW'(16);
    end else begin
      depth_c = depth_q;
    end
    shamt = 4'(depth_c - DepthW'(8));
  end

  // Full range: thr * (2^d - 1) >> 16
  assign full_prod = ({16'd0, pix_thr_q} << depth_c) - {16'd0, pix_thr_q};

  // Limited range: 16*f + (thr * 219 * f) >> 16
  assign thr_x219  = 24'(pix_thr_q) * 24'd219;
  assign ltd_prod  = {8'd0, thr_x219} << shamt;
  assign ltd_base  = 16'd16 << shamt;

  // Frame size clamp
  always_comb begin
    if (frame_pix_q == '0) begin
      npix = NpixW'(1);
    end else if (frame_pix_q > MaxFramePixels) begin
      npix = MaxFramePixels;
    end else begin
      npix = frame_pix_q;
    end
  end

  always_comb begin
    cfg_d.limit_full   = full_prod[31:16];
    cfg_d.limit_ltd    = ltd_base + ltd_prod[31:16];
    cfg_d.alpha_mode   = alpha_q;
    cfg_d.ratio_npix   = ProdW'(ratio_q) * ProdW'(npix);
    cfg_d.min_duration = min_dur_q;
  end

  // Derived values are registered and follow the registers in the next cycle
  always_ff @(posedge clk_i) begin
    cfg_q <= cfg_d;
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/bid_core.sv */
// ----------------------------------------------------------------------------
// bid_core
// Input register, per-pixel count, frame decision, interval tracking and
// result register with valid/stall on both sides.
// ----------------------------------------------------------------------------
module bid_core
  import bid_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  bid_cfg_t cfg_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  bid_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output bid_out_t out_data_o
);

  logic                   s1_valid_q;
  bid_in_t                s1_data_q;
  logic                   out_valid_q;
  bid_out_t               out_data_q;

  logic [CountW-1:0]      count_q, count_d;
  logic                   in_black_q, in_black_d;
  logic signed [PtsW-1:0] start_q, start_d;
  logic signed [PtsW-1:0] prev_q, prev_d;

  logic                   adv;
  logic                   fire;
  logic                   in_acc;
  logic [PixW-1:0]        limit;
  logic                   hit;
  logic [CountW-1:0]      count_inc;
  logic                   black;
  logic signed [PtsW-1:0] end_sel;
  logic signed [PtsW:0]   dur;
  logic                   long_enough;
  logic                   has_res;
  bid_out_t               res;

  // Handshake: the stage moves when the result register is free or drains
  assign adv        = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && adv;
  assign in_stall_o = s1_valid_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Pixel compare and saturating count
  assign limit     = (s1_data_q.full_range || cfg_i.alpha_mode) ?
                     cfg_i.limit_full : cfg_i.limit_ltd;
  assign hit       = s1_data_q.pixel_value <= limit;
  assign count_inc = (hit && count_q != CountMax) ? count_q + CountW'(1) : count_q;

  // Black frame: count * 65536 >= ratio * pixels
  assign black = {1'b0, count_inc, 16'd0} >= cfg_i.ratio_npix;

  // Interval length check, end is previous frame at end of stream
  assign end_sel     = s1_data_q.mode ? prev_q : s1_data_q.frame_pts;
  assign dur         = {end_sel[PtsW-1], end_sel} - {start_q[PtsW-1], start_q};
  assign long_enough = !dur[PtsW] && (dur[PtsW-1:0] >= PtsW'(cfg_i.min_duration));

  // Next state and result
  always_comb begin
    count_d    = count_q;
    in_black_d = in_black_q;
    start_d    = start_q;
    prev_d     = prev_q;
    has_res    = 1'b0;
    res        = '0;
    if (s1_data_q.mode) begin
      // end of stream
      count_d = '0;
      if (in_black_q) begin
        in_black_d               = 1'b0;
        has_res                  = 1'b1;
        res.end_event            = 1'b1;
        res.interval_long_enough = long_enough;
        res.interval_start       = start_q;
        res.interval_end         = prev_q;
      end
    end else if (!s1_data_q.frame_last) begin
      count_d = count_inc;
    end else begin
      count_d         = '0;
      prev_d          = s1_data_q.frame_pts;
      has_res         = 1'b1;
      res.frame_black = black;
      if (black) begin
        if (!in_black_q) begin
          in_black_d         = 1'b1;
          start_d            = s1_data_q.frame_pts;
          res.start_event    = 1'b1;
          res.interval_start = s1_data_q.frame_pts;
        end else begin
          res.interval_start = start_q;
        end
      end else if (in_black_q) begin
        in_black_d               = 1'b0;
        res.end_event            = 1'b1;
        res.interval_long_enough = long_enough;
        res.interval_start       = start_q;
        res.interval_end         = s1_data_q.frame_pts;
      end
    end
  end

  // Control and tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      in_black_q  <= 1'b0;
      start_q     <= '0;
      prev_q      <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= fire && has_res;
      end
      if (fire) begin
        count_q    <= count_d;
        in_black_q <= in_black_d;
        start_q    <= start_d;
        prev_q     <= prev_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_data_q <= in_data_i;
    end
    if (fire && has_res) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the black interval detector. A driver streams pixel
// and end-of-stream items from a queue, a monitor predicts each accepted item
// with a bit-accurate software detector and compares every result field.
// Configuration changes between phases, with random gaps on both channels but for one quiet phase.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bid_pkg::*;

  localparam logic        ModePixel  = 1'b0;
  localparam logic        ModeEos    = 1'b1;
  localparam int unsigned IdlePct    = 21;
  localparam int unsigned ErrShown   = 10;
  localparam int unsigned SettleCyc  = 4;
  localparam int unsigned NumPhases  = 13;
  localparam int unsigned QuietPhase = 6;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  bid_in_t              in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  bid_out_t             out_data_o;

  // Items waiting to be driven, and frame reports still due from the block
  bid_in_t  pixel_feed_q[$];
  bid_out_t frame_report_q[$];
  int unsigned err_cnt = 0;
  logic        no_gaps = 1'b0;

  // Shadow of the configuration registers
  logic [15:0]       cfg_thr       = PixThrReset;
  logic [RatioW-1:0] cfg_ratio     = RatioReset;
  logic [DurW-1:0]   cfg_min_dur   = MinDurReset;
  logic [NpixW-1:0]  cfg_frame_pix = FramePixReset;
  logic [DepthW-1:0] cfg_depth     = DepthReset;
  logic              cfg_alpha     = 1'b0;

  // Detector state as the block should hold it
  logic [CountW-1:0]      dark_count  = '0;
  logic                   in_interval = 1'b0;
  logic signed [PtsW-1:0] ivl_start   = '0;
  logic signed [PtsW-1:0] ivl_end     = '0;
  logic signed [PtsW-1:0] last_pts    = '0;

  black_interval_detector DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Bit depth clamped to 8..16
  function automatic int unsigned eff_depth();
    int unsigned d;
    d = cfg_depth;
    if (d < 8) d = 8;
    if (d > 16) d = 16;
    return d;
  endfunction

  // Highest sample value still counted as dark
  function automatic logic [15:0] black_level(logic full);
    int unsigned d;
    logic [63:0] f;
    logic [63:0] lim;
    d = eff_depth();
    f = 64'd1 << (d - 8);
    if (full || cfg_alpha) lim = (64'(cfg_thr) * ((64'd1 << d) - 64'd1)) >> 16;
    else lim = 64'd16 * f + ((64'(cfg_thr) * 64'd219 * f) >> 16);
    return 16'(lim);
  endfunction

  // Interval length check; an end before the start never qualifies
  function automatic logic long_enough();
    if (ivl_end < ivl_start) return 1'b0;
    return (64'(ivl_end) - 64'(ivl_start)) >= 64'(cfg_min_dur);
  endfunction

  function automatic bid_in_t pix_item(logic [15:0] v, logic full, logic is_last,
                                       logic [63:0] pts);
    bid_in_t it;
    it.mode        = ModePixel;
    it.pixel_value = v;
    it.full_range  = full;
    it.frame_last  = is_last;
    it.frame_pts   = pts;
    return it;
  endfunction

  // End of stream; the other fields carry noise
  function automatic bid_in_t eos_item();
    bid_in_t it;
    it.mode        = ModeEos;
    it.pixel_value = 16'($urandom);
    it.full_range  = 1'($urandom);
    it.frame_last  = 1'($urandom);
    it.frame_pts   = {$urandom, $urandom};
    return it;
  endfunction

  // Advance the detector by one item and queue the report it produces
  task automatic run_detector(bid_in_t it);
    bid_out_t    rep;
    logic [63:0] npix;
    logic        black;
    rep = '0;
    if (it.mode == ModeEos) begin
      dark_count = '0;
      if (!in_interval) return;
      in_interval = 1'b0;
      ivl_end = last_pts;
      rep.end_event            = 1'b1;
      rep.interval_long_enough = long_enough();
      rep.interval_start       = ivl_start;
      rep.interval_end         = ivl_end;
      frame_report_q.push_back(rep);
      return;
    end
    if (it.pixel_value <= black_level(it.full_range) && dark_count != CountMax)
      dark_count = dark_count + 1'b1;
    if (!it.frame_last) return;
    npix = 64'(cfg_frame_pix);
    if (npix == 0) npix = 1;
    if (npix > 64'(MaxFramePixels)) npix = 64'(MaxFramePixels);
    black = (64'(dark_count) << 16) >= (64'(cfg_ratio) * npix);
    rep.frame_black = black;
    if (black) begin
      if (!in_interval) begin
        in_interval = 1'b1;
        ivl_start = it.frame_pts;
        rep.start_event = 1'b1;
      end
      rep.interval_start = ivl_start;
    end else if (in_interval) begin
      in_interval = 1'b0;
      ivl_end = it.frame_pts;
      rep.end_event            = 1'b1;
      rep.interval_long_enough = long_enough();
      rep.interval_start       = ivl_start;
      rep.interval_end         = ivl_end;
    end
    last_pts = it.frame_pts;
    dark_count = '0;
    frame_report_q.push_back(rep);
  endtask

  task automatic note_error(string msg);
    err_cnt++;
    if (err_cnt <= ErrShown) $display("%0t ns: %s", $realtime, msg);
  endtask

  // One register write; the shadow copy follows at once since the block is idle
  task automatic write_reg(bid_reg_e idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      RegPixelThreshold: cfg_thr       = val[15:0];
      RegRatioThreshold: cfg_ratio     = val[RatioW-1:0];
      RegMinDuration:    cfg_min_dur   = val[DurW-1:0];
      RegFramePixels:    cfg_frame_pix = val[NpixW-1:0];
      RegBitDepth:       cfg_depth     = val[DepthW-1:0];
      RegAlphaMode:      cfg_alpha     = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [15:0] thr, logic [RatioW-1:0] ratio,
                            logic [DurW-1:0] mind, logic [NpixW-1:0] fp,
                            logic [DepthW-1:0] depth, logic alpha);
    write_reg(RegPixelThreshold, CfgDataW'(thr));
    write_reg(RegRatioThreshold, CfgDataW'(ratio));
    write_reg(RegMinDuration, CfgDataW'(mind));
    write_reg(RegFramePixels, CfgDataW'(fp));
    write_reg(RegBitDepth, CfgDataW'(depth));
    write_reg(RegAlphaMode, CfgDataW'(alpha));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every item is in and every report is out, then let the pipe settle
  task automatic drain();
    while (pixel_feed_q.size() != 0 || in_valid_i || frame_report_q.size() != 0)
      @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  // Frames in runs of dark and bright, with some noise frames, cut frames
  // and stray end-of-stream items
  task automatic gen_phase(int unsigned n_items);
    int unsigned sent, len, cut, kind, dark_pct, frame_len, k;
    logic full, mixed, dark_run, is_last;
    logic [15:0] lim, top, v;
    logic signed [63:0] ts;
    sent = 0;
    dark_run = 1'b0;
    ts = {$urandom, $urandom};
    if (cfg_frame_pix >= 1 && cfg_frame_pix <= 16) frame_len = cfg_frame_pix;
    else frame_len = $urandom_range(1, 6);
    top = 16'((32'd1 << eff_depth()) - 1);
    while (sent < n_items) begin
      kind = $urandom_range(99);
      if (kind < 4) begin
        pixel_feed_q.push_back(eos_item());
        sent++;
      end else begin
        if ($urandom_range(99) < 30) dark_run = !dark_run;
        len = ($urandom_range(99) < 85) ? frame_len : $urandom_range(1, 2 * frame_len + 1);
        cut = (kind < 7) ? $urandom_range(len - 1) : len;
        mixed = (kind >= 92);
        if (kind >= 85) dark_pct = $urandom_range(100);
        else if (dark_run) dark_pct = $urandom_range(1) ? 100 : $urandom_range(70, 100);
        else dark_pct = $urandom_range(40);
        full = 1'($urandom);
        case ($urandom_range(19))
          0:       ts = {$urandom, $urandom};
          1:       ts = ts - $urandom_range(1, 5000);
          default: ts = ts + $urandom_range(1, 3000);
        endcase
        for (k = 0; k < cut; k++) begin
          if (mixed) full = 1'($urandom);
          lim = black_level(full);
          if (mixed) v = 16'($urandom);
          else if ($urandom_range(99) < dark_pct)
            v = ($urandom_range(3) == 0) ? lim : 16'($urandom_range(lim));
          else
            v = ($urandom_range(3) == 0) ? lim + 16'd1 : 16'($urandom_range(lim + 1, top));
          is_last = (k == len - 1);
          pixel_feed_q.push_back(pix_item(v, full, is_last,
                                          is_last ? ts : {$urandom, $urandom}));
          sent++;
        end
        // frame cut short by end of stream
        if (cut < len) begin
          pixel_feed_q.push_back(eos_item());
          sent++;
        end
      end
    end
  endtask

  // Driver: a new item only once the current one has been taken
  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      if (pixel_feed_q.size() != 0 && (no_gaps || $urandom_range(99) >= IdlePct)) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pixel_feed_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: check reports against the oldest expectation, predict accepted items
  always @(posedge clk_i) begin
    bid_out_t want;
    bid_out_t got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = out_data_o;
        if (frame_report_q.size() == 0) begin
          note_error($sformatf("unexpected report %h", got));
        end else begin
          want = frame_report_q.pop_front();
          if (got.frame_black !== want.frame_black ||
              got.start_event !== want.start_event ||
              got.end_event !== want.end_event ||
              got.interval_long_enough !== want.interval_long_enough ||
              got.interval_start !== want.interval_start ||
              got.interval_end !== want.interval_end)
            note_error($sformatf(
              "exp blk %b st %b en %b long %b start %0d end %0d / got blk %b st %b en %b long %b start %0d end %0d",
              want.frame_black, want.start_event, want.end_event,
              want.interval_long_enough, want.interval_start, want.interval_end,
              got.frame_black, got.start_event, got.end_event,
              got.interval_long_enough, got.interval_start, got.interval_end));
        end
      end
      if (in_valid_i && !in_stall_o) run_detector(in_data_i);
      out_stall_i <= !no_gaps && ($urandom_range(99) < IdlePct);
    end
  end

  // Stimulus and phase control
  initial begin
    int unsigned       phase;
    logic [RatioW-1:0] r_ratio;
    logic [DurW-1:0]   r_min;
    logic [DepthW-1:0] r_depth;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at reset settings: one pixel per frame, dark up to
    // 37 in limited range and 25 in full range
    pixel_feed_q.push_back(eos_item());                         // nothing open yet
    pixel_feed_q.push_back(pix_item(16'd0, 1'b0, 1'b1, 64'h8000_0000_0000_0000));
    pixel_feed_q.push_back(pix_item(16'hFFFF, 1'b0, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF));
    pixel_feed_q.push_back(pix_item(16'd37, 1'b0, 1'b1, 64'd100));   // on the limit
    pixel_feed_q.push_back(pix_item(16'd38, 1'b0, 1'b1, 64'd50));    // ends before start
    pixel_feed_q.push_back(pix_item(16'd25, 1'b1, 1'b1, 64'd200));
    pixel_feed_q.push_back(pix_item(16'd26, 1'b1, 1'b1, 64'd300));
    pixel_feed_q.push_back(pix_item(16'd0, 1'b1, 1'b1, 64'd400));
    pixel_feed_q.push_back(pix_item(16'd0, 1'b0, 1'b1, 64'd500));
    pixel_feed_q.push_back(eos_item());                         // closes at last pts
    pixel_feed_q.push_back(pix_item(16'd0, 1'b0, 1'b0, 64'd0));
    pixel_feed_q.push_back(eos_item());                         // partial frame dropped
    pixel_feed_q.push_back(pix_item(16'hFFFF, 1'b1, 1'b1, 64'd600));
    pixel_feed_q.push_back(pix_item(16'd0, 1'b0, 1'b0, 64'd0));
    pixel_feed_q.push_back(pix_item(16'hFFFF, 1'b0, 1'b1, 64'd700)); // count spans pixels
    pixel_feed_q.push_back(eos_item());
    pixel_feed_q.push_back(eos_item());
    drain();

    // Random phases; the first three sit on the register extremes
    for (phase = 0; phase < NumPhases; phase++) begin
      r_ratio = ($urandom_range(9) == 0) ? RatioW'($urandom)
                                         : RatioW'($urandom_range(32768, 65536));
      r_min   = ($urandom_range(9) == 0) ? DurW'({$urandom, $urandom})
                                         : DurW'($urandom_range(20000));
      r_depth = ($urandom_range(6) == 0) ? DepthW'($urandom)
                                         : DepthW'($urandom_range(8, 16));
      case (phase)
        0: set_config(16'h0000, '0, '0, '0, '0, 1'b0);
        1: set_config(16'hFFFF, RatioW'(65536), '1, '1, '1, 1'b1);
        2: set_config(16'($urandom), '1, r_min, MaxFramePixels, DepthW'(16), 1'b0);
        default: set_config(16'($urandom), r_ratio, r_min,
                            NpixW'($urandom_range(1, 12)), r_depth, 1'($urandom));
      endcase
      no_gaps <= (phase == QuietPhase);
      gen_phase((phase < 3) ? 80 : 150);
      drain();
    end

    if (err_cnt == 0) begin
      $display("** black_interval_detector: PASSED **");
    end else begin
      $display("** black_interval_detector: FAILED **");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #3_000_000;
    $display("** black_interval_detector: FAILED **");
    $finish;
  end

endmodule

/* black_interval_detector.f */
rtl/core/bid_pkg.sv
rtl/core/bid_cfg_regs.sv
rtl/core/bid_core.sv
rtl/core/black_interval_detector.sv
bench/tb_top.sv
